// File: hdl/heater_pid_duty_controller_macros.svh
// ----------------------------------------------------------------------------
// Heater PID duty controller assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef HEATER_PID_DUTY_CONTROLLER_MACROS_SVH
`define HEATER_PID_DUTY_CONTROLLER_MACROS_SVH

`ifndef SYNTH
`define HPID_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define HPID_ASSERT_NEVER(label, clk, rst_n, prop, msg) \
  `HPID_ASSERT(label, clk, rst_n, !(prop), msg)
`else
`define HPID_ASSERT(label, clk, rst_n, prop, msg)
`define HPID_ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif

`endif

// File: hdl/hpid_pkg.sv
// ----------------------------------------------------------------------------
// Heater PID package
// Shared codes, types and fixed field widths.
// ----------------------------------------------------------------------------
package hpid_pkg;

  localparam int GAIN_WIDTH  = 16;
  localparam int MS_WIDTH    = 16;
  localparam int DUTY_WIDTH  = 8;
  localparam int LIMIT_WIDTH = 31;
  localparam int FRAC_BITS   = 16;
  localparam int MS_PER_S    = 1000;
  localparam int ADDR_WIDTH  = 5;
  localparam int DATA_WIDTH  = 32;

  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_ENABLE  = 2'd1,
    CMD_DISABLE = 2'd2,
    CMD_RESET   = 2'd3
  } hpid_cmd_e;

  typedef enum logic [2:0] {
    REG_TARGET   = 3'd0,
    REG_GAIN_P   = 3'd1,
    REG_GAIN_I   = 3'd2,
    REG_GAIN_D   = 3'd3,
    REG_LIMIT    = 3'd4,
    REG_EMERG    = 3'd5,
    REG_OUT_MIN  = 3'd6,
    REG_OUT_MAX  = 3'd7
  } hpid_reg_e;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } hpid_op_e;

  typedef struct packed {
    logic busy;
    logic done;
  } hpid_stat_t;

endpackage

// File: hdl/hpid_muldiv.sv
// ----------------------------------------------------------------------------
// Heater PID serial multiply/divide unit
// Shift-add multiply over a 16-bit multiplier, restoring divide one
// quotient bit per cycle. Operands and results are unsigned magnitudes.
// ----------------------------------------------------------------------------
module hpid_muldiv #(
  parameter int W = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  hpid_pkg::hpid_op_e   op_i,
  input  logic [W-1:0]         a_i,
  input  logic [W-1:0]         b_i,
  output hpid_pkg::hpid_stat_t stat_o,
  output logic [W-1:0]         res_o
);
  import hpid_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  hpid_op_e      op_q;
  logic [W-1:0]  acc_q, x_q, y_q;
  logic [W:0]    trial, diff;
  logic          ge, last;

  assign trial = {acc_q, x_q[W-1]};
  assign diff  = trial - {1'b0, y_q};
  assign ge    = (trial >= {1'b0, y_q});
  assign last  = (op_q == OP_MUL) ? (cnt_q == CW'(GAIN_WIDTH - 1)) : (cnt_q == CW'(W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      op_q  <= op_i;
      acc_q <= '0;
      x_q   <= a_i;
      y_q   <= b_i;
    end else if (busy_q) begin
      unique case (op_q)
        OP_MUL: begin
          if (y_q[0]) acc_q <= acc_q + x_q;
          x_q <= {x_q[W-2:0], 1'b0};
          y_q <= {1'b0, y_q[W-1:1]};
        end
        OP_DIV: begin
          acc_q <= ge ? diff[W-1:0] : trial[W-1:0];
          x_q   <= {x_q[W-2:0], ge};
        end
      endcase
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign res_o       = (op_q == OP_MUL) ? acc_q : x_q;

endmodule

// File: hdl/heater_pid_duty_controller.sv
// ----------------------------------------------------------------------------
// Heater PID duty controller
// PID loop with integral clamp and emergency stop, one result per command.
// ----------------------------------------------------------------------------
// Enable, disable, reset and samples taken while disabled or tripping the
// emergency stop go straight to the result stage. A PID sample runs five
// multiplies and two divides on one bit-serial multiply/divide unit,
// W = max(INTEGRAL_WIDTH+16, TEMP_WIDTH+28) (48 by default); the derivative
// divide is skipped when the elapsed time is zero. One command is in work at
// a time, and the result register lets the next command enter while a result
// waits.
module heater_pid_duty_controller #(
  parameter int TEMP_WIDTH     = 16,
  parameter int INTEGRAL_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hpid_pkg::ADDR_WIDTH-1:0]  paddr,
  input  logic [hpid_pkg::DATA_WIDTH-1:0]  pwdata,
  output logic [hpid_pkg::DATA_WIDTH-1:0]  prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       cmd_i,
  input  logic signed [TEMP_WIDTH-1:0]     measured_temp_i,
  input  logic [hpid_pkg::MS_WIDTH-1:0]    elapsed_ms_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [hpid_pkg::DUTY_WIDTH-1:0]  duty_o,
  output logic                             loop_enabled_o,
  output logic                             emergency_tripped_o
);
  import hpid_pkg::*;
  `include "heater_pid_duty_controller_macros.svh"

  localparam int TW  = TEMP_WIDTH;
  localparam int IW  = INTEGRAL_WIDTH;
  localparam int EW  = TW + 1;
  localparam int DEW = TW + 2;
  localparam int W   = (IW + 16 > TW + 28) ? IW + 16 : TW + 28;
  localparam int SW  = W + 2;
  localparam logic [SW-1:0] CAP = (SW'(1) << (IW - 1)) - SW'(1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_EMS, ST_Q, ST_P, ST_I, ST_D1, ST_D2, ST_DD, ST_SUM, ST_FIN
  } state_e;

  state_e                  state_q;
  logic signed [TW-1:0]    target_q, emerg_q;
  logic [GAIN_WIDTH-1:0]   gain_p_q, gain_i_q, gain_d_q;
  logic [LIMIT_WIDTH-1:0]  limit_q;
  logic [DUTY_WIDTH-1:0]   omin_q, omax_q;
  logic signed [IW-1:0]    integ_q;
  logic signed [EW-1:0]    prev_q, e_q;
  logic signed [DEW-1:0]   de_q;
  logic [MS_WIDTH-1:0]     ms_q;
  logic                    running_q, first_q, trip_q;
  logic [DUTY_WIDTH-1:0]   duty_q;
  logic signed [SW-1:0]    p_q, i_q, d_q;
  logic                    start_q;
  hpid_op_e                op_q;
  logic [W-1:0]            opa_q, opb_q;
  logic                    out_valid_q, out_en_q, out_trip_q;
  logic [DUTY_WIDTH-1:0]   out_duty_q;

  hpid_stat_t              mstat;
  logic [W-1:0]            mres;

  logic                    in_acc, cfg_wr;
  hpid_cmd_e               cmd;
  hpid_reg_e               widx;
  logic signed [EW-1:0]    e_new;
  logic signed [DEW-1:0]   de_new;
  logic [EW-1:0]           e_new_mag, e_mag;
  logic [IW-1:0]           integ_mag;
  logic [DEW-1:0]          de_mag;
  logic [MS_WIDTH-1:0]     ms_new;
  logic signed [SW-1:0]    res_pos, q_s, integ_sum, lim_s, integ_clamp;
  logic [SW-1:0]           lim_u;
  logic signed [SW-1:0]    sum_s, lo_s, hi_s, sum_lo, sum_hi;

  hpid_muldiv #(.W(W)) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .op_i    (op_q),
    .a_i     (opa_q),
    .b_i     (opb_q),
    .stat_o  (mstat),
    .res_o   (mres)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign cmd        = hpid_cmd_e'(cmd_i);
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign widx       = hpid_reg_e'(paddr[4:2]);
  assign pready     = 1'b1;

  assign e_new     = EW'(target_q) - EW'(measured_temp_i);
  assign de_new    = DEW'(e_new) - DEW'(prev_q);
  assign e_new_mag = e_new[EW-1] ? EW'(-e_new) : EW'(e_new);
  assign e_mag     = e_q[EW-1] ? EW'(-e_q) : EW'(e_q);
  assign integ_mag = integ_q[IW-1] ? IW'(-integ_q) : IW'(integ_q);
  assign de_mag    = de_q[DEW-1] ? DEW'(-de_q) : DEW'(de_q);
  assign ms_new    = first_q ? MS_WIDTH'(MS_PER_S) : elapsed_ms_i;

  assign res_pos     = $signed({2'b00, mres});
  assign q_s         = e_q[EW-1] ? -res_pos : res_pos;
  assign integ_sum   = SW'(integ_q) + q_s;
  assign lim_u       = (SW'(limit_q) > CAP) ? CAP : SW'(limit_q);
  assign lim_s       = $signed(lim_u);
  assign integ_clamp = (integ_sum > lim_s) ? lim_s :
                       ((integ_sum < -lim_s) ? -lim_s : integ_sum);

  assign sum_s  = p_q + i_q + d_q;
  assign lo_s   = $signed(SW'({omin_q, {FRAC_BITS{1'b0}}}));
  assign hi_s   = $signed(SW'({omax_q, {FRAC_BITS{1'b0}}}));
  assign sum_lo = (sum_s < lo_s) ? lo_s : sum_s;
  assign sum_hi = (sum_lo > hi_s) ? hi_s : sum_lo;

  always_comb begin
    unique case (paddr[4:2])
      REG_TARGET:  prdata = DATA_WIDTH'($unsigned(target_q));
      REG_GAIN_P:  prdata = DATA_WIDTH'(gain_p_q);
      REG_GAIN_I:  prdata = DATA_WIDTH'(gain_i_q);
      REG_GAIN_D:  prdata = DATA_WIDTH'(gain_d_q);
      REG_LIMIT:   prdata = DATA_WIDTH'(limit_q);
      REG_EMERG:   prdata = DATA_WIDTH'($unsigned(emerg_q));
      REG_OUT_MIN: prdata = DATA_WIDTH'(omin_q);
      REG_OUT_MAX: prdata = DATA_WIDTH'(omax_q);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      target_q    <= TW'(12800);
      gain_p_q    <= GAIN_WIDTH'(256);
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      limit_q     <= LIMIT_WIDTH'(2560000);
      emerg_q     <= TW'(15360);
      omin_q      <= '0;
      omax_q      <= DUTY_WIDTH'(255);
      integ_q     <= '0;
      prev_q      <= '0;
      e_q         <= '0;
      de_q        <= '0;
      ms_q        <= '0;
      running_q   <= 1'b0;
      first_q     <= 1'b1;
      trip_q      <= 1'b0;
      duty_q      <= '0;
      p_q         <= '0;
      i_q         <= '0;
      d_q         <= '0;
      start_q     <= 1'b0;
      op_q        <= OP_MUL;
      opa_q       <= '0;
      opb_q       <= '0;
      out_valid_q <= 1'b0;
      out_en_q    <= 1'b0;
      out_trip_q  <= 1'b0;
      out_duty_q  <= '0;
    end else begin
      start_q <= 1'b0;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            trip_q  <= 1'b0;
            state_q <= ST_FIN;
            unique case (cmd)
              CMD_SAMPLE: begin
                if (!running_q) begin
                  duty_q <= '0;
                end else if (measured_temp_i >= emerg_q) begin
                  running_q <= 1'b0;
                  duty_q    <= '0;
                  integ_q   <= '0;
                  prev_q    <= '0;
                  trip_q    <= 1'b1;
                end else begin
                  e_q     <= e_new;
                  de_q    <= de_new;
                  prev_q  <= e_new;
                  ms_q    <= ms_new;
                  first_q <= 1'b0;
                  start_q <= 1'b1;
                  op_q    <= OP_MUL;
                  opa_q   <= W'(e_new_mag);
                  opb_q   <= W'(ms_new);
                  state_q <= ST_EMS;
                end
              end
              CMD_ENABLE: begin
                running_q <= 1'b1;
                integ_q   <= '0;
                prev_q    <= '0;
              end
              CMD_DISABLE: begin
                running_q <= 1'b0;
                duty_q    <= '0;
              end
              CMD_RESET: begin
                integ_q <= '0;
                prev_q  <= '0;
                duty_q  <= '0;
              end
            endcase
          end
        end
        ST_EMS: begin
          if (mstat.done) begin
            start_q <= 1'b1;
            op_q    <= OP_DIV;
            opa_q   <= mres;
            opb_q   <= W'(MS_PER_S);
            state_q <= ST_Q;
          end
        end
        ST_Q: begin
          if (mstat.done) begin
            integ_q <= IW'(integ_clamp);
            start_q <= 1'b1;
            op_q    <= OP_MUL;
            opa_q   <= W'(e_mag);
            opb_q   <= W'(gain_p_q);
            state_q <= ST_P;
          end
        end
        ST_P: begin
          if (mstat.done) begin
            p_q     <= e_q[EW-1] ? -res_pos : res_pos;
            start_q <= 1'b1;
            op_q    <= OP_MUL;
            opa_q   <= W'(integ_mag);
            opb_q   <= W'(gain_i_q);
            state_q <= ST_I;
          end
        end
        ST_I: begin
          if (mstat.done) begin
            i_q     <= integ_q[IW-1] ? -res_pos : res_pos;
            start_q <= 1'b1;
            op_q    <= OP_MUL;
            opa_q   <= W'(de_mag);
            opb_q   <= W'(gain_d_q);
            state_q <= ST_D1;
          end
        end
        ST_D1: begin
          if (mstat.done) begin
            start_q <= 1'b1;
            op_q    <= OP_MUL;
            opa_q   <= mres;
            opb_q   <= W'(MS_PER_S);
            state_q <= ST_D2;
          end
        end
        ST_D2: begin
          if (mstat.done) begin
            if (ms_q == '0) begin
              d_q     <= '0;
              state_q <= ST_SUM;
            end else begin
              start_q <= 1'b1;
              op_q    <= OP_DIV;
              opa_q   <= mres;
              opb_q   <= W'(ms_q);
              state_q <= ST_DD;
            end
          end
        end
        ST_DD: begin
          if (mstat.done) begin
            d_q     <= de_q[DEW-1] ? -res_pos : res_pos;
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          duty_q  <= sum_hi[FRAC_BITS +: DUTY_WIDTH];
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_duty_q  <= duty_q;
            out_en_q    <= running_q;
            out_trip_q  <= trip_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (cfg_wr) begin
        unique case (widx)
          REG_TARGET: begin
            target_q <= TW'(pwdata);
            integ_q  <= '0;
            prev_q   <= '0;
          end
          REG_GAIN_P: begin
            gain_p_q <= pwdata[GAIN_WIDTH-1:0];
            integ_q  <= '0;
          end
          REG_GAIN_I: begin
            gain_i_q <= pwdata[GAIN_WIDTH-1:0];
            integ_q  <= '0;
          end
          REG_GAIN_D: begin
            gain_d_q <= pwdata[GAIN_WIDTH-1:0];
            integ_q  <= '0;
          end
          REG_LIMIT:   limit_q <= pwdata[LIMIT_WIDTH-1:0];
          REG_EMERG:   emerg_q <= TW'(pwdata);
          REG_OUT_MIN: omin_q  <= pwdata[DUTY_WIDTH-1:0];
          REG_OUT_MAX: omax_q  <= pwdata[DUTY_WIDTH-1:0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign duty_o              = out_duty_q;
  assign loop_enabled_o      = out_en_q;
  assign emergency_tripped_o = out_trip_q;

  `HPID_ASSERT(a_off_no_duty, clk_i, rst_ni, (out_valid_o && !loop_enabled_o) |-> (duty_o == '0), "duty while loop disabled")
  `HPID_ASSERT_NEVER(a_trip_running, clk_i, rst_ni, out_valid_o && emergency_tripped_o && loop_enabled_o, "trip left loop enabled")
  `HPID_ASSERT(a_idle_unit, clk_i, rst_ni, (state_q == ST_IDLE) |-> !mstat.busy, "arith unit busy while idle")

endmodule

// File: bench/heater_pid_duty_controller_tb.sv
// ----------------------------------------------------------------------------
// Heater PID duty controller testbench
// Drives commands and register writes into the controller and compares every
// result with an in-bench fixed-point PID prediction, under random idling.
// ----------------------------------------------------------------------------
module heater_pid_duty_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hpid_pkg::*;

  class pid_scoreboard;
    logic signed [15:0] target;
    logic signed [15:0] emerg;
    logic [15:0] kp, ki, kd;
    logic [30:0] limit;
    logic [7:0] out_min, out_max;
    longint integ, prev_err;
    bit running, first_pending;
    logic [7:0] cur_duty;
    logic [9:0] expected_q[$];
    int errors;
    int results;

    function void reset_state();
      target = 16'sd12800; kp = 256; ki = 0; kd = 0; limit = 31'd2560000;
      emerg = 16'sd15360; out_min = 0; out_max = 255;
      integ = 0; prev_err = 0; running = 0; first_pending = 1; cur_duty = 0;
      errors = 0; results = 0;
      expected_q.delete();
    endfunction

    function void write_reg(hpid_reg_e idx, logic [31:0] val);
      case (idx)
        REG_TARGET: begin
          target = val[15:0]; integ = 0; prev_err = 0;
        end
        REG_GAIN_P: begin
          kp = val[15:0]; integ = 0;
        end
        REG_GAIN_I: begin
          ki = val[15:0]; integ = 0;
        end
        REG_GAIN_D: begin
          kd = val[15:0]; integ = 0;
        end
        REG_LIMIT: limit = val[30:0];
        REG_EMERG: emerg = val[15:0];
        REG_OUT_MIN: out_min = val[7:0];
        default: out_max = val[7:0];
      endcase
    endfunction

    function void pid_update(longint meas, longint ms_in);
      longint e, ms, lim, p, i, d, s, lo, hi;
      e = longint'(target) - meas;
      ms = first_pending ? 1000 : ms_in;
      first_pending = 0;
      lim = limit;
      if (lim > 64'sd2147483647) lim = 64'sd2147483647;
      integ += (e * ms) / 1000;
      if (integ > lim) integ = lim;
      if (integ < -lim) integ = -lim;
      p = longint'(kp) * e;
      i = longint'(ki) * integ;
      d = 0;
      if (ms != 0) d = (longint'(kd) * (e - prev_err) * 1000) / ms;
      prev_err = e;
      s = p + i + d;
      lo = longint'(out_min) << 16;
      hi = longint'(out_max) << 16;
      if (s < lo) s = lo;
      if (s > hi) s = hi;
      cur_duty = s[23:16];
    endfunction

    function void note_request(hpid_cmd_e cmd, logic signed [15:0] meas, logic [15:0] ms);
      bit trip;
      trip = 0;
      case (cmd)
        CMD_SAMPLE: begin
          if (!running) cur_duty = 0;
          else if (meas >= emerg) begin
            running = 0; cur_duty = 0; integ = 0; prev_err = 0; trip = 1;
          end else pid_update(longint'(meas), longint'(ms));
        end
        CMD_ENABLE: begin
          running = 1; integ = 0; prev_err = 0;
        end
        CMD_DISABLE: begin
          running = 0; cur_duty = 0;
        end
        default: begin
          integ = 0; prev_err = 0; cur_duty = 0;
        end
      endcase
      expected_q.push_back({cur_duty, running, trip});
    endfunction

    function void check_result(logic [7:0] duty, logic en, logic trip);
      logic [9:0] exp_v;
      results++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result duty=%0d en=%0b trip=%0b", $time, duty, en, trip);
        errors++;
        return;
      end
      exp_v = expected_q.pop_front();
      if (exp_v[9:2] !== duty) begin
        $display("%0t: duty expected %0d actual %0d", $time, exp_v[9:2], duty);
        errors++;
      end
      if (exp_v[1] !== en) begin
        $display("%0t: loop_enabled expected %0b actual %0b", $time, exp_v[1], en);
        errors++;
      end
      if (exp_v[0] !== trip) begin
        $display("%0t: emergency_tripped expected %0b actual %0b", $time, exp_v[0], trip);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [ADDR_WIDTH-1:0] paddr;
  logic [DATA_WIDTH-1:0] pwdata, prdata;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [1:0] cmd_i;
  logic signed [15:0] measured_temp_i;
  logic [15:0] elapsed_ms_i;
  logic [7:0] duty_o;
  logic loop_enabled_o, emergency_tripped_o;

  pid_scoreboard sb;
  int send_idle_pct, recv_stall_pct;
  longint cycle_count;
  int sent;

  heater_pid_duty_controller dut (.*);

  always begin
    clk_i = 1'b0; #5;
    clk_i = 1'b1; #5;
  end

  initial begin
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid_i = 0; out_ready_i = 0; cmd_i = CMD_SAMPLE;
    measured_temp_i = '0; elapsed_ms_i = '0;
    send_idle_pct = 0; recv_stall_pct = 0;
    rst_ni = 0;
    sb = new();
    sb.reset_state();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("heater_pid_duty_controller verification failed");
      $finish;
    end
  end
  initial cycle_count = 0;

  // Sample results at the rising edge, refresh ready at the falling edge.
  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(duty_o, loop_enabled_o, emergency_tripped_o);

  always @(negedge clk_i)
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  task automatic write_reg(hpid_reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel = 1; penable = 0; pwrite = 1; paddr = ADDR_WIDTH'(idx) << 2; pwdata = val;
    @(negedge clk_i);
    penable = 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic send_request(hpid_cmd_e cmd, logic [15:0] meas, logic [15:0] ms);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid_i = 1; cmd_i = cmd; measured_temp_i = meas; elapsed_ms_i = ms;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(cmd, meas, ms);
    sent++;
    @(negedge clk_i);
    in_valid_i = 0;
  endtask

  task automatic drain();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic random_regs(bit extreme);
    write_reg(REG_TARGET, extreme ? ($urandom_range(1) ? 32'h7FFF : 32'h8000)
                                  : 32'(16'($urandom_range(2000, 20000))));
    write_reg(REG_GAIN_P, extreme ? 32'hFFFF : $urandom_range(1200));
    write_reg(REG_GAIN_I, extreme ? 32'hFFFF : $urandom_range(300));
    write_reg(REG_GAIN_D, extreme ? 32'hFFFF : $urandom_range(300));
    write_reg(REG_LIMIT, extreme ? 32'h7FFFFFFF : $urandom_range(3000000));
    write_reg(REG_EMERG, extreme ? 32'h7FFF : $urandom_range(14000, 24000));
    write_reg(REG_OUT_MIN, $urandom_range(extreme ? 255 : 60));
    write_reg(REG_OUT_MAX, extreme ? $urandom_range(255) : $urandom_range(120, 255));
  endtask

  task automatic random_request();
    int r;
    logic [15:0] ms;
    r = $urandom_range(99);
    ms = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(2000));
    if ($urandom_range(19) == 0) ms = 0;
    if (r < 75)
      send_request(CMD_SAMPLE, ($urandom_range(9) == 0) ? 16'($urandom)
                   : 16'(int'(sb.target) + $urandom_range(3000) - 1500), ms);
    else if (r < 85) send_request(CMD_ENABLE, 16'($urandom), 16'($urandom));
    else if (r < 92) send_request(CMD_DISABLE, 16'($urandom), 16'($urandom));
    else send_request(CMD_RESET, 16'($urandom), 16'($urandom));
  endtask

  initial begin
    sent = 0;
    @(posedge rst_ni);
    // Directed: disabled sample, first sample, zero elapsed time, emergency.
    send_request(CMD_SAMPLE, 16'h1000, 16'd100);
    send_request(CMD_ENABLE, 0, 0);
    send_request(CMD_SAMPLE, 16'h2800, 16'hFFFF);
    send_request(CMD_SAMPLE, 16'h2900, 16'd0);
    send_request(CMD_SAMPLE, 16'h8000, 16'd1);
    send_request(CMD_SAMPLE, 16'h7FFF, 16'hFFFF);
    send_request(CMD_SAMPLE, 16'h3000, 16'd10);
    send_request(CMD_ENABLE, 0, 0);
    send_request(CMD_ENABLE, 0, 0);
    send_request(CMD_SAMPLE, 16'h3C00, 16'd10);
    send_request(CMD_RESET, 16'hFFFF, 16'hFFFF);
    send_request(CMD_ENABLE, 0, 0);
    send_request(CMD_SAMPLE, 16'h2000, 16'd500);
    send_request(CMD_RESET, 0, 0);
    send_request(CMD_SAMPLE, 16'h2100, 16'd500);
    send_request(CMD_DISABLE, 0, 0);
    drain();
    random_regs(1);
    write_reg(REG_OUT_MIN, 32'd200);
    write_reg(REG_OUT_MAX, 32'd100);
    send_request(CMD_ENABLE, 0, 0);
    send_request(CMD_SAMPLE, 16'h8000, 16'hFFFF);
    send_request(CMD_SAMPLE, 16'h7FFE, 16'd0);
    send_request(CMD_SAMPLE, 16'h8000, 16'd1);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 53; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 53; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      random_regs(ph == 7);
      send_request(CMD_ENABLE, 0, 0);
      for (int k = 0; k < 56; k++) random_request();
      drain();
    end
    write_reg(REG_TARGET, 32'h0000FFFF);
    write_reg(REG_OUT_MIN, 32'd0);
    write_reg(REG_OUT_MAX, 32'd255);
    send_request(CMD_ENABLE, 0, 0);
    send_request(CMD_SAMPLE, 16'hFF00, 16'd250);
    drain();
    $display("Ran %0d commands with %0d results checked across eight register settings",
             sent, sb.results);
    $display("and four idling mixes, including extreme gains, limits and inverted clamps.");
    if (sb.errors == 0)
      $display("heater_pid_duty_controller verification clean");
    else
      $display("heater_pid_duty_controller verification failed");
    $finish;
  end
endmodule
